[hw/rtl/pda_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pda_pkg
// Shared types and constants of the delta apply engine.
// ----------------------------------------------------------------------------
package pda_pkg;

   localparam int BASE_DEPTH = 65536;
   localparam int BASE_AW    = $clog2(BASE_DEPTH);
   localparam int BLEN_W     = BASE_AW + 1;

   typedef enum logic [1:0] {
      OP_BASE  = 2'd0,
      OP_DELTA = 2'd1,
      OP_TICK  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK              = 3'd0,
      ST_BASE_MISMATCH   = 3'd1,
      ST_COPY_OOB        = 3'd2,
      ST_ZERO_ADD        = 3'd3,
      ST_ADD_PAST_END    = 3'd4,
      ST_TARGET_MISMATCH = 3'd5,
      ST_TRUNCATED       = 3'd6,
      ST_COPY_PENDING    = 3'd7
   } status_type;

   typedef enum logic [5:0] {
      PH_BASE_HDR   = 6'b000001,
      PH_TARGET_HDR = 6'b000010,
      PH_INSTR      = 6'b000100,
      PH_COPY_ARGS  = 6'b001000,
      PH_ADD        = 6'b010000,
      PH_COPY_EMIT  = 6'b100000
   } phase_type;

   // Varint shift kept as a count of 7-bit groups; this value means 70 or more.
   localparam logic [3:0] SHIDX_SAT = 4'd10;

endpackage

[hw/rtl/pack_delta_apply.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pack_delta_apply
// Rebuilds a target object from a loaded base and a git style delta stream.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake            Payload
// req      in   req_valid/req_ready  req_operation, req_data_byte, req_delta_last
// rsp      out  rsp_valid/rsp_ready  rsp_out_byte, rsp_has_byte, rsp_done_res,
//                                    rsp_status
//
// One word is accepted per cycle unless a stalled output drops req_ready.
// Copy bytes are read from the base memory, one synchronous read port, so a
// result first sits in a stage that waits for the read data, then in the
// output register. A stalled output holds both stages and then drops req_ready.
// Reset is synchronous and clears the decoder; base memory contents are kept.
module pack_delta_apply
   import pda_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_data_byte,
   input  logic       req_delta_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_byte,
   output logic       rsp_done_res,
   output logic [2:0] rsp_status
);

   // Decoder state.
   logic [BLEN_W-1:0] base_len_ff, base_len_in;
   phase_type         phase_ff, phase_in;
   logic [63:0]       acc_ff, acc_in;
   logic [3:0]        shidx_ff, shidx_in;
   logic [63:0]       tsize_ff, tsize_in;
   logic [6:0]        flags_ff, flags_in;
   logic [31:0]       coff_ff, coff_in;
   logic [23:0]       csize_ff, csize_in;
   logic [16:0]       crem_ff, crem_in;
   logic [6:0]        arem_ff, arem_in;
   logic [63:0]       ocnt_ff, ocnt_in;
   logic              err_ff, err_in;
   logic              endp_ff, endp_in;

   // Result of the word being accepted.
   logic       res_v;
   logic [7:0] res_byte;
   logic       res_has;
   logic       res_done;
   status_type res_st;
   logic       res_mem;
   logic       clr;

   // Memory ports.
   logic [7:0]         mem [BASE_DEPTH];
   logic               mem_we, mem_re;
   logic [BASE_AW-1:0] mem_ra;
   logic [7:0]         mem_rd_ff;

   // Pipeline stages.
   logic       s1_v_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_has_ff, s1_done_ff, s1_mem_ff;
   status_type s1_st_ff;
   logic       s1_move, acc_word;
   logic       rsp_v_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_has_ff, rsp_done_ff;
   status_type rsp_st_ff;

   // Helpers.
   logic [6:0]  chunk;
   logic [63:0] chunk_sh;
   logic        vdone;
   logic [2:0]  pos;
   logic [24:0] size_v;
   logic [32:0] end_sum;
   logic        oob;
   logic [7:0]  b;
   logic        last;

   assign b        = req_data_byte;
   assign last     = req_delta_last;
   assign chunk    = b[6:0];
   assign vdone    = !b[7];
   assign s1_move  = !rsp_v_ff || rsp_ready;
   assign req_ready = !s1_v_ff || s1_move;
   assign acc_word = req_valid && req_ready;

   always_comb begin
      chunk_sh = '0;
      for (int k = 0; k < 10; k++) begin
         if (shidx_ff == 4'(k)) begin
            chunk_sh = 64'(chunk) << (7 * k);
         end
      end
   end

   always_comb begin
      pos = 3'd0;
      for (int k = 6; k >= 0; k--) begin
         if (flags_ff[k]) begin
            pos = 3'(k);
         end
      end
   end

   always_comb begin
      base_len_in = base_len_ff;
      phase_in    = phase_ff;
      acc_in      = acc_ff;
      shidx_in    = shidx_ff;
      tsize_in    = tsize_ff;
      flags_in    = flags_ff;
      coff_in     = coff_ff;
      csize_in    = csize_ff;
      crem_in     = crem_ff;
      arem_in     = arem_ff;
      ocnt_in     = ocnt_ff;
      err_in      = err_ff;
      endp_in     = endp_ff;
      res_v       = 1'b0;
      res_byte    = '0;
      res_has     = 1'b0;
      res_done    = 1'b0;
      res_st      = ST_OK;
      res_mem     = 1'b0;
      clr         = 1'b0;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_ra      = coff_ff[BASE_AW-1:0];
      size_v      = '0;
      end_sum     = '0;
      oob         = 1'b0;

      if (acc_word) begin
         case (req_operation)
            OP_BASE: begin
               if (!err_ff && phase_ff == PH_BASE_HDR && shidx_ff == '0 &&
                   base_len_ff < BLEN_W'(BASE_DEPTH)) begin
                  mem_we      = 1'b1;
                  base_len_in = base_len_ff + 1'b1;
               end
            end
            OP_DELTA: begin
               if (err_ff) begin
                  clr = last;
               end else begin
                  case (phase_ff)
                     PH_BASE_HDR, PH_TARGET_HDR: begin
                        acc_in   = acc_ff | chunk_sh;
                        shidx_in = (shidx_ff == SHIDX_SAT) ? SHIDX_SAT : shidx_ff + 1'b1;
                        if (!vdone) begin
                           if (last) begin
                              res_v = 1'b1; res_done = 1'b1; res_st = ST_TRUNCATED;
                              clr = 1'b1;
                           end
                        end else if (phase_ff == PH_BASE_HDR) begin
                           if (acc_in != 64'(base_len_ff)) begin
                              res_v = 1'b1; res_done = 1'b1; res_st = ST_BASE_MISMATCH;
                              clr = last; err_in = !last;
                           end else if (last) begin
                              res_v = 1'b1; res_done = 1'b1; res_st = ST_TRUNCATED;
                              clr = 1'b1;
                           end else begin
                              acc_in   = '0;
                              shidx_in = '0;
                              phase_in = PH_TARGET_HDR;
                           end
                        end else begin
                           tsize_in = acc_in;
                           phase_in = PH_INSTR;
                           if (last) begin
                              res_v = 1'b1; res_done = 1'b1;
                              res_st = (ocnt_ff == acc_in) ? ST_OK : ST_TARGET_MISMATCH;
                              clr = 1'b1;
                           end
                        end
                     end
                     PH_INSTR, PH_COPY_ARGS: begin
                        if (phase_ff == PH_INSTR && !b[7]) begin
                           if (b[6:0] == '0) begin
                              res_v = 1'b1; res_done = 1'b1; res_st = ST_ZERO_ADD;
                              clr = last; err_in = !last;
                           end else if (last) begin
                              res_v = 1'b1; res_done = 1'b1; res_st = ST_ADD_PAST_END;
                              clr = 1'b1;
                           end else begin
                              arem_in  = b[6:0];
                              phase_in = PH_ADD;
                           end
                        end else begin
                           if (phase_ff == PH_INSTR) begin
                              flags_in = b[6:0];
                              coff_in  = '0;
                              csize_in = '0;
                           end else begin
                              flags_in      = flags_ff & ~(7'(1) << pos);
                              if (!pos[2]) begin
                                 coff_in[8*pos[1:0] +: 8] = b;
                              end else begin
                                 csize_in[8*pos[1:0] +: 8] = b;
                              end
                           end
                           if (flags_in == '0) begin
                              size_v  = (csize_in == '0) ? 25'h10000 : {1'b0, csize_in};
                              end_sum = {1'b0, coff_in} + 33'(size_v);
                              oob     = end_sum > 33'(base_len_ff);
                              if (oob) begin
                                 res_v = 1'b1; res_done = 1'b1; res_st = ST_COPY_OOB;
                                 clr = last; err_in = !last;
                              end else begin
                                 crem_in  = size_v[16:0];
                                 phase_in = PH_COPY_EMIT;
                                 endp_in  = last;
                              end
                           end else if (last) begin
                              res_v = 1'b1; res_done = 1'b1; res_st = ST_TRUNCATED;
                              clr = 1'b1;
                           end else begin
                              phase_in = PH_COPY_ARGS;
                           end
                        end
                     end
                     PH_ADD: begin
                        if (last && arem_ff > 7'd1) begin
                           res_v = 1'b1; res_done = 1'b1; res_st = ST_ADD_PAST_END;
                           clr = 1'b1;
                        end else begin
                           ocnt_in  = ocnt_ff + 1'b1;
                           arem_in  = arem_ff - 1'b1;
                           if (arem_in == '0) begin
                              phase_in = PH_INSTR;
                           end
                           res_v    = 1'b1;
                           res_byte = b;
                           res_has  = 1'b1;
                           if (last) begin
                              res_done = 1'b1;
                              res_st = (ocnt_in == tsize_ff) ? ST_OK : ST_TARGET_MISMATCH;
                              clr = 1'b1;
                           end
                        end
                     end
                     default: begin
                        res_v = 1'b1; res_done = 1'b1; res_st = ST_COPY_PENDING;
                        clr = last; err_in = !last;
                     end
                  endcase
               end
            end
            OP_TICK: begin
               if (!err_ff && phase_ff == PH_COPY_EMIT && crem_ff != '0) begin
                  mem_re  = 1'b1;
                  coff_in = coff_ff + 1'b1;
                  crem_in = crem_ff - 1'b1;
                  ocnt_in = ocnt_ff + 1'b1;
                  res_v   = 1'b1;
                  res_has = 1'b1;
                  res_mem = 1'b1;
                  if (crem_in == '0) begin
                     phase_in = PH_INSTR;
                     if (endp_ff) begin
                        res_done = 1'b1;
                        res_st = (ocnt_in == tsize_ff) ? ST_OK : ST_TARGET_MISMATCH;
                        clr = 1'b1;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (clr) begin
         base_len_in = '0;
         phase_in    = PH_BASE_HDR;
         acc_in      = '0;
         shidx_in    = '0;
         tsize_in    = '0;
         flags_in    = '0;
         coff_in     = '0;
         csize_in    = '0;
         crem_in     = '0;
         arem_in     = '0;
         ocnt_in     = '0;
         err_in      = 1'b0;
         endp_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[base_len_ff[BASE_AW-1:0]] <= b;
      end
      if (mem_re) begin
         mem_rd_ff <= mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_len_ff <= '0;
         phase_ff    <= PH_BASE_HDR;
         acc_ff      <= '0;
         shidx_ff    <= '0;
         tsize_ff    <= '0;
         flags_ff    <= '0;
         coff_ff     <= '0;
         csize_ff    <= '0;
         crem_ff     <= '0;
         arem_ff     <= '0;
         ocnt_ff     <= '0;
         err_ff      <= 1'b0;
         endp_ff     <= 1'b0;
         s1_v_ff     <= 1'b0;
         rsp_v_ff    <= 1'b0;
      end else begin
         base_len_ff <= base_len_in;
         phase_ff    <= phase_in;
         acc_ff      <= acc_in;
         shidx_ff    <= shidx_in;
         tsize_ff    <= tsize_in;
         flags_ff    <= flags_in;
         coff_ff     <= coff_in;
         csize_ff    <= csize_in;
         crem_ff     <= crem_in;
         arem_ff     <= arem_in;
         ocnt_ff     <= ocnt_in;
         err_ff      <= err_in;
         endp_ff     <= endp_in;
         if (req_ready) begin
            s1_v_ff <= res_v && acc_word;
         end
         if (s1_move) begin
            rsp_v_ff <= s1_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         s1_byte_ff <= res_byte;
         s1_has_ff  <= res_has;
         s1_done_ff <= res_done;
         s1_st_ff   <= res_st;
         s1_mem_ff  <= res_mem;
      end
      // Copy bytes pick up the registered read data here.
      if (s1_move) begin
         rsp_byte_ff <= s1_mem_ff ? mem_rd_ff : s1_byte_ff;
         rsp_has_ff  <= s1_has_ff;
         rsp_done_ff <= s1_done_ff;
         rsp_st_ff   <= s1_st_ff;
      end
   end

   assign rsp_valid    = rsp_v_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_has_byte = rsp_has_ff;
   assign rsp_done_res = rsp_done_ff;
   assign rsp_status   = rsp_st_ff;

`ifndef SYNTHESIS
   a_status_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_status == ST_OK)
      else $error("nonzero status without end of object");

   a_error_has_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK && rsp_status != ST_TARGET_MISMATCH
      |-> !rsp_has_byte)
      else $error("error result carries a byte");

   a_copy_has_bytes: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_COPY_EMIT |-> crem_ff != '0)
      else $error("copy emit phase with nothing left");

   a_base_len_bound: assert property (@(posedge clock) disable iff (reset)
      base_len_ff <= BLEN_W'(BASE_DEPTH))
      else $error("base length beyond memory depth");
`endif

endmodule
